// ===== sv/drce_pkg.sv =====
// Shared types and constants for the Dirichlet row/column elimination core.
`timescale 1ns / 1ps

package drce_pkg;

   localparam int INDEX_W = 6;
   localparam int DATA_W  = 32;
   localparam int SUM_W   = 48;
   localparam int FRAC_W  = 16;
   localparam int PROD_W  = 2 * DATA_W;

   localparam logic signed [DATA_W-1:0] Q16_ONE  = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q16_ZERO = '0;
   localparam logic signed [DATA_W-1:0] LOAD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] LOAD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_SET   = 2'd1,
      OP_ENTRY = 2'd2
   } opcode_type;

   // Request after acceptance; prescribed values arrive from the RAM alongside.
   typedef struct packed {
      logic                     is_clear;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [DATA_W-1:0] entry;
      logic signed [DATA_W-1:0] load;
      logic                     last;
      logic                     rc;
      logic                     cc;
   } s1_type;

   // After the multiplier.
   typedef struct packed {
      logic                     is_clear;
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [DATA_W-1:0] eout;
      logic signed [DATA_W-1:0] load;
      logic                     last;
      logic                     rc;
      logic signed [DATA_W-1:0] row_value;
      logic signed [SUM_W-1:0]  term;
   } s2_type;

   // After the row accumulator.
   typedef struct packed {
      logic [INDEX_W-1:0]       row;
      logic [INDEX_W-1:0]       col;
      logic signed [DATA_W-1:0] eout;
      logic signed [DATA_W-1:0] load;
      logic                     last;
      logic                     rc;
      logic signed [DATA_W-1:0] row_value;
      logic signed [SUM_W-1:0]  sum;
   } s3_type;

endpackage

// ===== sv/drce_ram.sv =====
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module drce_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr_b,
   output logic [WIDTH-1:0]                 rd_data_a,
   output logic [WIDTH-1:0]                 rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

// ===== sv/dirichlet_row_column_elimination_core.sv =====
// Top level of the Dirichlet row/column elimination core.
//
//   Channel  Direction  Handshake            Contents
//   req_     in         req_valid/req_ready  clear, set constraint, or matrix entry
//   rsp_     out        rsp_valid/rsp_ready  modified entry and, at row end, the load
//
// One request is accepted per cycle while req_ready is high. A matrix entry passes
// through RAM read, multiply, row accumulate and load correction into the output
// register. The row accumulator is a combinational add-and-saturate loop on the
// row-sum register, which sets the rate of one entry per clock when the output does not stall.
// Reset clears the constraint flags, the row sum and all stage valids at once;
// the prescribed-value RAM needs no clearing since a value is only used under
// its flag. Each stage holds when the stage after it is full and stalled, so
// bubbles fill up before req_ready drops.

`timescale 1ns / 1ps

module dirichlet_row_column_elimination_core #(
   parameter int MAX_DOFS = 64
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [5:0]           req_dof_index,
   input  logic signed [31:0]   req_constraint_value,
   input  logic [5:0]           req_row_index,
   input  logic [5:0]           req_col_index,
   input  logic signed [31:0]   req_entry_value,
   input  logic signed [31:0]   req_load_value,
   input  logic                 req_last_in_row,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_entry_out,
   output logic [5:0]           rsp_row_out,
   output logic [5:0]           rsp_col_out,
   output logic signed [31:0]   rsp_load_out,
   output logic                 rsp_load_valid,
   output logic                 rsp_load_saturated
);

   localparam int INDEX_W = drce_pkg::INDEX_W;
   localparam int DATA_W  = drce_pkg::DATA_W;
   localparam int SUM_W   = drce_pkg::SUM_W;
   localparam int FRAC_W  = drce_pkg::FRAC_W;
   localparam int PROD_W  = drce_pkg::PROD_W;

   // Indexes are six bits wide, so entries past 2**INDEX_W are never addressed.
   localparam int TABLE_DEPTH = (MAX_DOFS < (2 ** INDEX_W)) ? MAX_DOFS : (2 ** INDEX_W);
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam logic [INDEX_W:0] TABLE_DEPTH_W = (INDEX_W + 1)'(TABLE_DEPTH);

   // Handshake and stage control.
   logic                  accept;
   logic                  enter_pipe;
   logic                  s1_ready, s2_ready, s3_ready, out_ready;
   logic                  s1_v_ff, s2_v_ff, s3_v_ff;
   logic                  s1_v_in, s2_v_in, s3_v_in;
   drce_pkg::opcode_type  op;

   // Constraint flags are flip-flops so that a clear takes effect at once.
   logic [TABLE_DEPTH-1:0] flags_ff, flags_in;

   logic                  dof_in_range, row_in_range, col_in_range;
   logic [ADDR_W-1:0]     dof_addr, row_addr, col_addr;
   logic                  ram_wr_en;
   logic [DATA_W-1:0]     col_value_raw, row_value_raw;

   drce_pkg::s1_type      s1_ff, s1_in;
   drce_pkg::s2_type      s2_ff, s2_in;
   drce_pkg::s3_type      s3_ff, s3_in;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [SUM_W:0]    sum_wide;
   logic signed [SUM_W-1:0]  sum_sat;
   logic signed [PROD_W-1:0] product;
   logic signed [SUM_W+1:0]  load_diff;
   logic signed [DATA_W-1:0] load_clip;
   logic                     load_clipped;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_entry_ff, rsp_load_ff;
   logic [INDEX_W-1:0]       rsp_row_ff, rsp_col_ff;
   logic                     rsp_lvalid_ff, rsp_lsat_ff;

   // ------------------------------------------------------------------------
   // Ready chain. A clear token leaves the second stage without a result, so
   // it never waits on the stages behind it.
   // ------------------------------------------------------------------------
   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign s3_ready  = !s3_v_ff || out_ready;
   assign s2_ready  = !s2_v_ff || s2_ff.is_clear || s3_ready;
   assign s1_ready  = !s1_v_ff || s2_ready;
   assign req_ready = s1_ready;

   assign op         = drce_pkg::opcode_type'(req_opcode);
   assign accept     = req_valid && req_ready;
   assign enter_pipe = accept && (op == drce_pkg::OP_ENTRY || op == drce_pkg::OP_CLEAR);

   // ------------------------------------------------------------------------
   // Table lookup and update, done at the accepting edge.
   // ------------------------------------------------------------------------
   assign dof_in_range = {1'b0, req_dof_index} < TABLE_DEPTH_W;
   assign row_in_range = {1'b0, req_row_index} < TABLE_DEPTH_W;
   assign col_in_range = {1'b0, req_col_index} < TABLE_DEPTH_W;
   assign dof_addr     = req_dof_index[ADDR_W-1:0];
   assign row_addr     = req_row_index[ADDR_W-1:0];
   assign col_addr     = req_col_index[ADDR_W-1:0];
   assign ram_wr_en    = accept && (op == drce_pkg::OP_SET) && dof_in_range;

   always_comb begin
      flags_in = flags_ff;
      if (accept) begin
         case (op)
            drce_pkg::OP_CLEAR: begin
               flags_in = '0;
            end
            drce_pkg::OP_SET: begin
               if (dof_in_range) begin
                  flags_in[dof_addr] = 1'b1;
               end
            end
            default: begin
               flags_in = flags_ff;
            end
         endcase
      end
   end

   drce_ram #(
      .WIDTH (DATA_W),
      .DEPTH (TABLE_DEPTH)
   ) u_value_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (dof_addr),
      .wr_data   (req_constraint_value),
      .rd_en     (enter_pipe),
      .rd_addr_a (col_addr),
      .rd_addr_b (row_addr),
      .rd_data_a (col_value_raw),
      .rd_data_b (row_value_raw)
   );

   // Stage 1: the request, with its constraint flags, waits for the RAM data.
   always_comb begin
      s1_v_in = s1_v_ff;
      s1_in   = s1_ff;
      if (s1_ready) begin
         s1_v_in        = enter_pipe;
         s1_in.is_clear = (op == drce_pkg::OP_CLEAR);
         s1_in.row      = req_row_index;
         s1_in.col      = req_col_index;
         s1_in.entry    = req_entry_value;
         s1_in.load     = req_load_value;
         s1_in.last     = req_last_in_row;
         s1_in.rc       = row_in_range && flags_ff[row_addr];
         s1_in.cc       = col_in_range && flags_ff[col_addr];
      end
   end

   // Stage 2: exact product, floored to Q32.16 by dropping the low fraction bits.
   assign product = s1_ff.entry * $signed(col_value_raw);

   always_comb begin
      s2_v_in = s2_v_ff;
      s2_in   = s2_ff;
      if (s2_ready) begin
         s2_v_in           = s1_v_ff;
         s2_in.is_clear    = s1_ff.is_clear;
         s2_in.row         = s1_ff.row;
         s2_in.col         = s1_ff.col;
         s2_in.load        = s1_ff.load;
         s2_in.last        = s1_ff.last;
         s2_in.rc          = s1_ff.rc;
         s2_in.row_value   = $signed(row_value_raw);
         s2_in.term        = s1_ff.cc ? product[PROD_W-1:FRAC_W] : '0;
         if (s1_ff.rc || s1_ff.cc) begin
            s2_in.eout = (s1_ff.row == s1_ff.col) ? drce_pkg::Q16_ONE : drce_pkg::Q16_ZERO;
         end else begin
            s2_in.eout = s1_ff.entry;
         end
      end
   end

   // Stage 3: row accumulator with saturation to the 48-bit range.
   assign sum_wide = {s2_ff.term[SUM_W-1], s2_ff.term} + {sum_ff[SUM_W-1], sum_ff};

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? drce_pkg::SUM_MIN : drce_pkg::SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   always_comb begin
      sum_in  = sum_ff;
      s3_v_in = s3_v_ff;
      s3_in   = s3_ff;
      if (s3_ready) begin
         s3_v_in = 1'b0;
      end
      if (s2_v_ff && s2_ff.is_clear) begin
         sum_in = '0;
      end else if (s2_v_ff && s3_ready) begin
         sum_in = s2_ff.last ? '0 : sum_sat;
      end
      if (s3_ready) begin
         s3_v_in         = s2_v_ff && !s2_ff.is_clear;
         s3_in.row       = s2_ff.row;
         s3_in.col       = s2_ff.col;
         s3_in.eout      = s2_ff.eout;
         s3_in.load      = s2_ff.load;
         s3_in.last      = s2_ff.last;
         s3_in.rc        = s2_ff.rc;
         s3_in.row_value = s2_ff.row_value;
         s3_in.sum       = sum_sat;
      end
   end

   // Output: load minus row sum, clipped to Q16.16.
   assign load_diff = $signed({{(SUM_W - DATA_W + 2){s3_ff.load[DATA_W-1]}}, s3_ff.load})
                    - $signed({{2{s3_ff.sum[SUM_W-1]}}, s3_ff.sum});

   always_comb begin
      if (load_diff[SUM_W+1:DATA_W-1] == '0 || load_diff[SUM_W+1:DATA_W-1] == '1) begin
         load_clip    = load_diff[DATA_W-1:0];
         load_clipped = 1'b0;
      end else begin
         load_clip    = load_diff[SUM_W+1] ? drce_pkg::LOAD_MIN : drce_pkg::LOAD_MAX;
         load_clipped = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff     <= '0;
         sum_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         flags_ff     <= flags_in;
         sum_ff       <= sum_in;
         s1_v_ff      <= s1_v_in;
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      if (out_ready) begin
         rsp_entry_ff  <= s3_ff.eout;
         rsp_row_ff    <= s3_ff.row;
         rsp_col_ff    <= s3_ff.col;
         rsp_lvalid_ff <= s3_ff.last;
         if (!s3_ff.last) begin
            rsp_load_ff <= drce_pkg::Q16_ZERO;
            rsp_lsat_ff <= 1'b0;
         end else if (s3_ff.rc) begin
            rsp_load_ff <= s3_ff.row_value;
            rsp_lsat_ff <= 1'b0;
         end else begin
            rsp_load_ff <= load_clip;
            rsp_lsat_ff <= load_clipped;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_entry_out      = rsp_entry_ff;
   assign rsp_row_out        = rsp_row_ff;
   assign rsp_col_out        = rsp_col_ff;
   assign rsp_load_out       = rsp_load_ff;
   assign rsp_load_valid     = rsp_lvalid_ff;
   assign rsp_load_saturated = rsp_lsat_ff;

`ifndef ASSERT_OFF
   // A clear that leaves the second stage empties the row sum.
   a_clear_zeroes_sum: assert property (@(posedge clock) disable iff (reset)
      (s2_v_ff && s2_ff.is_clear) |=> (sum_ff == '0))
      else $error("row sum not cleared after clear request");

   // The core only refuses a request when every stage is full and the output stalls.
   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_v_ff && s2_v_ff && s3_v_ff && rsp_valid_ff && !rsp_ready))
      else $error("request refused with room in the pipeline");

   // Saturation is only reported together with a finished row load.
   a_sat_with_load: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_load_saturated) |-> rsp_load_valid)
      else $error("saturation flagged without a row load");
`endif

endmodule
